### hdl/rfcc_pkg.sv
// shared types and constants for the route feasibility and cost check
`timescale 1ns / 1ps

package rfcc_pkg;

  localparam int DEF_MAX_ROUTE_NODES = 1024;

  localparam int ID_W   = 10;
  localparam int DEM_W  = 16;
  localparam int TW_W   = 24;
  localparam int CAP_W  = 24;
  localparam int CPD_W  = 16;
  localparam int CLK_W  = 26;
  localparam int DIST_W = 34;
  localparam int COST_W = 48;
  localparam int CFG_W  = 24;
  localparam int ADDR_W = 3;

  localparam logic [CLK_W-1:0]  CLOCK_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;

  // register indexes of the configuration port
  localparam logic [ADDR_W-1:0] REG_DEPOT_ID          = 3'd0;
  localparam logic [ADDR_W-1:0] REG_VEHICLE_CAPACITY  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_ROUTE_START_TIME  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_FIXED_COST        = 3'd3;
  localparam logic [ADDR_W-1:0] REG_COST_PER_DISTANCE = 3'd4;

  localparam logic [CPD_W-1:0] CPD_RESET = 16'd256;

  // route summary handed from the accumulator to the result pipeline
  typedef struct packed {
    logic              depot_ok;
    logic              two_node;
    logic              late;
    logic [DIST_W-1:0] dist_sum;
  } route_sum_t;

endpackage

### hdl/rfcc_accum.sv
// per-route running sums, clock and window tracking
`timescale 1ns / 1ps

module rfcc_accum
  import rfcc_pkg::*;
#(
  parameter int MAX_ROUTE_NODES = DEF_MAX_ROUTE_NODES,
  localparam int TOT_W = $clog2(MAX_ROUTE_NODES) + DEM_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [ID_W-1:0]  node_id,
  input  logic [DEM_W-1:0] delivery,
  input  logic [DEM_W-1:0] pickup,
  input  logic [TW_W-1:0]  window_open,
  input  logic [TW_W-1:0]  window_close,
  input  logic [DEM_W-1:0] service_time,
  input  logic [DEM_W-1:0] travel_time,
  input  logic [DEM_W-1:0] travel_distance,
  input  logic             last_node,
  input  logic [ID_W-1:0]  depot_id,
  input  logic [TW_W-1:0]  route_start_time,
  output route_sum_t       sum,
  output logic [TOT_W-1:0] total,
  output logic [TOT_W-1:0] max_prefix
);

  localparam int CNT_W = $clog2(MAX_ROUTE_NODES + 2);
  localparam int PRE_W = TOT_W + 1;

  logic [CNT_W-1:0]        node_count, node_count_next;
  logic                    first_at_depot, first_at_depot_next;
  logic                    window_violated, window_violated_next;
  logic [TOT_W-1:0]        total_delivery, total_delivery_next;
  logic signed [PRE_W-1:0] net_prefix, net_prefix_next;
  logic signed [PRE_W-1:0] max_net, max_net_next;
  logic [CLK_W-1:0]        clock_time, clock_time_next;
  logic [DIST_W-1:0]       distance_sum, distance_sum_next;

  logic [CLK_W:0]          t_arrive;
  logic [CLK_W:0]          t_start;
  logic [CLK_W+1:0]        t_leave;
  logic [DIST_W:0]         dist_add;
  logic signed [PRE_W-1:0] pick_s, del_s;

  always_comb begin
    pick_s   = $signed({{(PRE_W-DEM_W){1'b0}}, pickup});
    del_s    = $signed({{(PRE_W-DEM_W){1'b0}}, delivery});
    t_arrive = {1'b0, clock_time} + (CLK_W+1)'(travel_time);
    t_start  = (t_arrive < (CLK_W+1)'(window_open)) ? (CLK_W+1)'(window_open) : t_arrive;
    t_leave  = {1'b0, t_start} + (CLK_W+2)'(service_time);
    dist_add = {1'b0, distance_sum} + (DIST_W+1)'(travel_distance);

    node_count_next = (node_count <= CNT_W'(MAX_ROUTE_NODES)) ? node_count + 1'b1 : node_count;

    if (node_count == '0) begin
      // first node starts the route afresh
      first_at_depot_next  = (node_id == depot_id);
      window_violated_next = 1'b0;
      total_delivery_next  = TOT_W'(delivery);
      net_prefix_next      = '0;
      max_net_next         = '0;
      clock_time_next      = CLK_W'(route_start_time);
      distance_sum_next    = '0;
    end else begin
      first_at_depot_next  = first_at_depot;
      window_violated_next = window_violated || (t_arrive > (CLK_W+1)'(window_close));
      total_delivery_next  = total_delivery + TOT_W'(delivery);
      net_prefix_next      = net_prefix + pick_s - del_s;
      max_net_next         = (net_prefix_next > max_net) ? net_prefix_next : max_net;
      clock_time_next      = (t_leave > (CLK_W+2)'(CLOCK_MAX)) ? CLOCK_MAX
                                                               : t_leave[CLK_W-1:0];
      distance_sum_next    = dist_add[DIST_W] ? DIST_MAX : dist_add[DIST_W-1:0];
    end
  end

  always_comb begin
    sum.depot_ok = first_at_depot_next && (node_id == depot_id) &&
                   (node_count_next <= CNT_W'(MAX_ROUTE_NODES));
    sum.two_node = (node_count_next == CNT_W'(2));
    sum.late     = window_violated_next;
    sum.dist_sum = distance_sum_next;
    total        = total_delivery_next;
    max_prefix   = max_net_next[TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (take) begin
      node_count <= last_node ? '0 : node_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      first_at_depot  <= first_at_depot_next;
      window_violated <= window_violated_next;
      total_delivery  <= total_delivery_next;
      net_prefix      <= net_prefix_next;
      max_net         <= max_net_next;
      clock_time      <= clock_time_next;
      distance_sum    <= distance_sum_next;
    end
  end

endmodule

### hdl/rfcc_result.sv
// three-stage result pipeline: input capture, capacity check with distance product, output word
`timescale 1ns / 1ps

module rfcc_result
  import rfcc_pkg::*;
#(
  parameter int MAX_ROUTE_NODES = DEF_MAX_ROUTE_NODES,
  localparam int TOT_W = $clog2(MAX_ROUTE_NODES) + DEM_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  route_sum_t        sum,
  input  logic [TOT_W-1:0]  total,
  input  logic [TOT_W-1:0]  max_prefix,
  input  logic [CAP_W-1:0]  vehicle_capacity,
  input  logic [CAP_W-1:0]  fixed_cost,
  input  logic [CPD_W-1:0]  cost_per_distance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              feasible,
  output logic [COST_W-1:0] route_cost
);

  localparam int PK_W   = (TOT_W + 1 > CAP_W) ? TOT_W + 1 : CAP_W;
  localparam int PROD_W = DIST_W + CPD_W;

  logic a_valid, b_valid;
  logic a_ready, b_ready, c_ready;

  route_sum_t       a_sum;
  logic [TOT_W-1:0] a_total, a_max;

  logic              b_feasible, b_use_cost;
  logic [PROD_W-1:0] b_prod;

  logic [PK_W-1:0] peak;
  logic            over_cap;

  function automatic logic [TOT_W:0] total_ext(input logic [TOT_W-1:0] x,
                                               input logic [TOT_W-1:0] y);
    return {1'b0, x} + {1'b0, y};
  endfunction

  assign c_ready  = !out_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign peak     = PK_W'(total_ext(a_total, a_max));
  assign over_cap = peak > PK_W'(vehicle_capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_sum   <= sum;
      a_total <= total;
      a_max   <= max_prefix;
    end
    if (b_ready && a_valid) begin
      // depot-to-depot pair is free whatever the loads and windows
      b_feasible <= a_sum.depot_ok && (a_sum.two_node || (!over_cap && !a_sum.late));
      b_use_cost <= a_sum.depot_ok && !a_sum.two_node && !over_cap && !a_sum.late;
      b_prod     <= PROD_W'(a_sum.dist_sum) * PROD_W'(cost_per_distance);
    end
    if (c_ready && b_valid) begin
      feasible   <= b_feasible;
      // sum stays below 2^43, so no saturation is reachable at 48 bits
      route_cost <= b_use_cost ? COST_W'(fixed_cost) + COST_W'(b_prod[PROD_W-1:8])
                               : '0;
    end
  end

endmodule

### hdl/route_feasibility_cost_check.sv
// top level of the route feasibility and cost check
// result path: a last node taken at the input passes the input capture, capacity check
// and output word registers before its result word is valid
// throughput: one node word per cycle; running sums update at the input handshake
// the result pipeline holds three words, so input stalls only when all are waiting
// reset: synchronous, active high; clears pipeline valids and the node counter,
// config registers return to zero except cost_per_distance, which returns to 256
`timescale 1ns / 1ps

module route_feasibility_cost_check
  import rfcc_pkg::*;
#(
  parameter int MAX_ROUTE_NODES = DEF_MAX_ROUTE_NODES
) (
  input  logic               clk,
  input  logic               rst,
  // node words
  input  logic               s_tvalid,
  output logic               s_tready,
  // node_id, delivery, pickup, window_open, window_close, service_time,
  // travel_time, travel_distance, zero pad
  input  logic [143:0]       s_tdata,
  // last_node
  input  logic               s_tlast,
  // result words
  output logic               m_tvalid,
  input  logic               m_tready,
  // feasible, route_cost, zero pad
  output logic [55:0]        m_tdata,
  // configuration writes
  input  logic               cfg_wen,
  input  logic [ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int TOT_W = $clog2(MAX_ROUTE_NODES) + DEM_W;

  // config registers
  logic [ID_W-1:0]  depot_id;
  logic [CAP_W-1:0] vehicle_capacity;
  logic [TW_W-1:0]  route_start_time;
  logic [CAP_W-1:0] fixed_cost;
  logic [CPD_W-1:0] cost_per_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      depot_id          <= '0;
      vehicle_capacity  <= '0;
      route_start_time  <= '0;
      fixed_cost        <= '0;
      cost_per_distance <= CPD_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_DEPOT_ID:          depot_id          <= cfg_wdata[ID_W-1:0];
        REG_VEHICLE_CAPACITY:  vehicle_capacity  <= cfg_wdata[CAP_W-1:0];
        REG_ROUTE_START_TIME:  route_start_time  <= cfg_wdata[TW_W-1:0];
        REG_FIXED_COST:        fixed_cost        <= cfg_wdata[CAP_W-1:0];
        REG_COST_PER_DISTANCE: cost_per_distance <= cfg_wdata[CPD_W-1:0];
        default: ; // writes past the register list are dropped
      endcase
    end
  end

  // unpack the node word
  logic [ID_W-1:0]  node_id;
  logic [DEM_W-1:0] delivery, pickup, service_time, travel_time, travel_distance;
  logic [TW_W-1:0]  window_open, window_close;

  assign node_id         = s_tdata[9:0];
  assign delivery        = s_tdata[25:10];
  assign pickup          = s_tdata[41:26];
  assign window_open     = s_tdata[65:42];
  assign window_close    = s_tdata[89:66];
  assign service_time    = s_tdata[105:90];
  assign travel_time     = s_tdata[121:106];
  assign travel_distance = s_tdata[137:122];

  logic take;
  logic res_ready;
  assign s_tready = res_ready;
  assign take     = s_tvalid && s_tready;

  route_sum_t       sum;
  logic [TOT_W-1:0] total, max_prefix;

  // running route state; its outputs already include the word being taken
  rfcc_accum #(
    .MAX_ROUTE_NODES(MAX_ROUTE_NODES)
  ) u_accum (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .node_id          (node_id),
    .delivery         (delivery),
    .pickup           (pickup),
    .window_open      (window_open),
    .window_close     (window_close),
    .service_time     (service_time),
    .travel_time      (travel_time),
    .travel_distance  (travel_distance),
    .last_node        (s_tlast),
    .depot_id         (depot_id),
    .route_start_time (route_start_time),
    .sum              (sum),
    .total            (total),
    .max_prefix       (max_prefix)
  );

  logic              feasible;
  logic [COST_W-1:0] route_cost;

  // only the last node of a route enters the result pipeline
  rfcc_result #(
    .MAX_ROUTE_NODES(MAX_ROUTE_NODES)
  ) u_result (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (take && s_tlast),
    .in_ready          (res_ready),
    .sum               (sum),
    .total             (total),
    .max_prefix        (max_prefix),
    .vehicle_capacity  (vehicle_capacity),
    .fixed_cost        (fixed_cost),
    .cost_per_distance (cost_per_distance),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .feasible          (feasible),
    .route_cost        (route_cost)
  );

  assign m_tdata = {7'b0, route_cost, feasible};

endmodule
